// ----- hw/rtl/spq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the strict priority queue
// Word layouts, status and mode codes, controller commands and defaults.
// ----------------------------------------------------------------------------
package spq_pkg;

  // Default geometry of the queue bank
  localparam int NumQueuesDef  = 8;
  localparam int QueueDepthDef = 16;

  // Limit register
  localparam int               LimitW     = 5;
  localparam logic [LimitW-1:0] LimitReset = 5'd16;

  // Mode codes of an input word
  localparam logic ModeEnq = 1'b0;
  localparam logic ModeDeq = 1'b1;

  // Status codes of a result word
  localparam logic [1:0] StEnq   = 2'd0;
  localparam logic [1:0] StDrop  = 2'd1;
  localparam logic [1:0] StDeq   = 2'd2;
  localparam logic [1:0] StEmpty = 2'd3;

  // Input word
  typedef struct packed {
    logic        mode;
    logic [7:0]  priority_in;
    logic [15:0] size_in;
    logic [7:0]  flow_in;
  } spq_in_t;

  // Result word
  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  class_out;
    logic [15:0] size_out;
    logic [7:0]  flow_out;
  } spq_out_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;  // capture the input word
    logic exec;  // select queue, update pointers, access the store
    logic emit;  // result registers are valid this cycle
  } spq_cmd_t;

endpackage

// ----- hw/rtl/spq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_ctrl: sequencing controller of the strict priority queue
// Walks each accepted word through load, execute and result cycles.
// ----------------------------------------------------------------------------
module spq_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  output spq_pkg::spq_cmd_t cmd_o
);
  import spq_pkg::*;

  typedef enum logic [2:0] {
    SIdle = 3'b001,
    SExec = 3'b010,
    SDone = 3'b100
  } state_e;

  state_e state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d   = state_q;
    cmd_o     = '0;
    unique case (state_q)
      SIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = SExec;
        end
      end
      SExec: begin
        cmd_o.exec = 1'b1;
        state_d    = SDone;
      end
      SDone: begin
        cmd_o.emit = 1'b1;
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = SExec;
        end else begin
          state_d = SIdle;
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  assign busy = (state_q == SExec);

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hw/rtl/spq_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_datapath: queue bank of the strict priority queue
// Holds the packet store, per-queue pointers and counts, and the limit.
// ----------------------------------------------------------------------------
module spq_datapath #(
  parameter int NumQueues  = spq_pkg::NumQueuesDef,
  parameter int QueueDepth = spq_pkg::QueueDepthDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  spq_pkg::spq_cmd_t             cmd_i,
  input  spq_pkg::spq_in_t              item_i,
  input  logic                          cfg_valid_i,
  input  logic [spq_pkg::LimitW-1:0]    cfg_data_i,
  output spq_pkg::spq_out_t             result_o
);
  import spq_pkg::*;

  localparam int QW      = $clog2(NumQueues);
  localparam int IW      = $clog2(QueueDepth);
  localparam int CW      = $clog2(QueueDepth + 1);
  localparam int LW      = (CW > LimitW) ? CW : LimitW;
  localparam int Entries = NumQueues * QueueDepth;
  localparam int AW      = $clog2(Entries);

  typedef logic [QW-1:0] qmap_t [256];

  // Priority to queue map, built at elaboration
  function automatic qmap_t build_qmap();
    qmap_t m;
    for (int i = 0; i < 256; i++) begin
      m[i] = QW'(i % NumQueues);
    end
    return m;
  endfunction

  localparam qmap_t QMap = build_qmap();

  logic [LimitW-1:0] limit_q;
  spq_in_t           item_q;
  logic [IW-1:0]     head_q [NumQueues];
  logic [IW-1:0]     tail_q [NumQueues];
  logic [CW-1:0]     fill_q [NumQueues];
  logic [23:0]       mem_q  [Entries];
  logic [23:0]       rdata_q;

  logic [1:0]        res_status_q;
  logic [QW-1:0]     res_class_q;
  logic [15:0]       res_size_q;
  logic [7:0]        res_flow_q;
  logic              res_mem_q;

  logic [NumQueues-1:0] nonempty;
  logic                 found;
  logic [QW-1:0]        q_deq;
  logic [QW-1:0]        q_sel;
  logic [IW-1:0]        head_sel, tail_sel, head_nxt, tail_nxt;
  logic [CW-1:0]        fill_sel;
  logic                 is_deq, full_hit, mem_we, mem_re;
  logic [AW-1:0]        base, waddr, raddr;

  // Limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LimitReset;
    end else if (cfg_valid_i) begin
      limit_q <= cfg_data_i;
    end
  end

  // Capture the input word
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  // Find the highest-numbered non-empty queue
  always_comb begin
    q_deq = '0;
    for (int i = 0; i < NumQueues; i++) begin
      nonempty[i] = (fill_q[i] != '0);
      if (nonempty[i]) begin
        q_deq = QW'(i);
      end
    end
  end
  assign found = |nonempty;

  // Select the queue and its pointers
  assign is_deq   = (item_q.mode == ModeDeq);
  assign q_sel    = is_deq ? q_deq : QMap[item_q.priority_in];
  assign head_sel = head_q[q_sel];
  assign tail_sel = tail_q[q_sel];
  assign fill_sel = fill_q[q_sel];
  assign head_nxt = (head_sel == IW'(QueueDepth - 1)) ? '0 : head_sel + 1'b1;
  assign tail_nxt = (tail_sel == IW'(QueueDepth - 1)) ? '0 : tail_sel + 1'b1;

  // Drop when the count reaches the limit, capped at the queue depth
  assign full_hit = (LW'(fill_sel) >= LW'(limit_q)) || (fill_sel == CW'(QueueDepth));

  assign mem_we = cmd_i.exec && !is_deq && !full_hit;
  assign mem_re = cmd_i.exec && is_deq && found;
  assign base   = AW'(q_sel) * AW'(QueueDepth);
  assign waddr  = base + AW'(tail_sel);
  assign raddr  = base + AW'(head_sel);

  // Advance pointers and counts
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumQueues; i++) begin
        head_q[i] <= '0;
        tail_q[i] <= '0;
        fill_q[i] <= '0;
      end
    end else if (mem_we) begin
      tail_q[q_sel] <= tail_nxt;
      fill_q[q_sel] <= fill_sel + 1'b1;
    end else if (mem_re) begin
      head_q[q_sel] <= head_nxt;
      fill_q[q_sel] <= fill_sel - 1'b1;
    end
  end

  // Packet store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[waddr] <= {item_q.size_in, item_q.flow_in};
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rdata_q <= mem_q[raddr];
    end
  end

  // Result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_mem_q <= 1'b0;
    end else if (cmd_i.exec) begin
      res_mem_q <= is_deq && found;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      if (is_deq) begin
        res_status_q <= found ? StDeq : StEmpty;
        res_class_q  <= found ? q_deq : '0;
        res_size_q   <= '0;
        res_flow_q   <= '0;
      end else begin
        res_status_q <= full_hit ? StDrop : StEnq;
        res_class_q  <= q_sel;
        res_size_q   <= item_q.size_in;
        res_flow_q   <= item_q.flow_in;
      end
    end
  end

  // Drive the result word
  always_comb begin
    result_o.status    = res_status_q;
    result_o.class_out = 3'(res_class_q);
    result_o.size_out  = res_mem_q ? rdata_q[23:8] : res_size_q;
    result_o.flow_out  = res_mem_q ? rdata_q[7:0] : res_flow_q;
  end

endmodule

// ----- hw/rtl/strict_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// strict_priority_queue: strict priority packet scheduler
// Order: a word taken with start moves to the execute state and then to the
//   done state, which raises the result strobe. Start is taken again in the strobe
//   cycle, bound by the registered read of the packet store.
// Reset: pointers and counts clear at once, limit returns to 16; the packet
//   store is not cleared. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module strict_priority_queue #(
  parameter int NumQueues  = spq_pkg::NumQueuesDef,
  parameter int QueueDepth = spq_pkg::QueueDepthDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  spq_pkg::spq_in_t           item_i,
  output logic                       result_valid_o,
  output spq_pkg::spq_out_t          result_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [spq_pkg::LimitW-1:0] cfg_data_i
);
  import spq_pkg::*;

  spq_cmd_t cmd;

  // Limit writes are always taken
  assign cfg_ready_o    = 1'b1;
  assign result_valid_o = cmd.emit;

  spq_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  spq_datapath #(
    .NumQueues  (NumQueues),
    .QueueDepth (QueueDepth)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .item_i      (item_i),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .result_o    (result_o)
  );

endmodule

// ----- hw/rtl/spq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker: port-level checks of the strict priority queue
// Watches the command handshake and result strobe over time.
// ----------------------------------------------------------------------------
module spq_port_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              result_valid_o,
  input spq_pkg::spq_out_t result_o
);
  import spq_pkg::*;

  // Each taken word yields its result strobe after the execute state
  a_result_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |-> ##2 result_valid_o)
    else $error("result strobe missing after accepted word");

  // Busy is always followed by a result
  a_busy_then_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> result_valid_o)
    else $error("busy cycle not followed by result");

  // Results never come in consecutive cycles
  a_strobe_spacing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe in consecutive cycles");

  // An empty report carries zero fields
  a_empty_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (result_o.status == StEmpty) |->
      (result_o.class_out == '0) && (result_o.size_out == '0) &&
      (result_o.flow_out == '0))
    else $error("empty report with nonzero fields");

endmodule

bind strict_priority_queue spq_port_checker u_spq_port_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

// ----- test/spq_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_checker: scoreboard for the strict priority queue
// Watches the input, result and limit channels. Keeps a shadow copy of the
// queue bank, works out the result of every accepted input word, and compares
// each result word with the oldest outstanding prediction, field by field.
// ----------------------------------------------------------------------------
module spq_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic                       busy_i,
  input  spq_pkg::spq_in_t           item_i,
  input  logic                       result_valid_i,
  input  spq_pkg::spq_out_t          result_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [spq_pkg::LimitW-1:0] cfg_data_i,
  output int                         mismatch_count_o,
  output int                         results_due_o
);
  import spq_pkg::*;

  localparam int NumQ  = NumQueuesDef;
  localparam int Depth = QueueDepthDef;

  // Shadow of the queue bank and the limit register
  logic [LimitW-1:0] limit_q;
  logic [23:0]       pkt_mem [NumQ][Depth];
  int                head_idx [NumQ];
  int                tail_idx [NumQ];
  int                fill_cnt [NumQ];

  // Predicted result words, oldest first
  spq_out_t          due_results [$];

  initial mismatch_count_o = 0;

  // Print one line per mismatch and count it
  task automatic flag_mismatch(string msg);
    $display("ERROR at %0t ns: %s", $realtime, msg);
    mismatch_count_o++;
  endtask

  // Apply one input word to the shadow bank and return its result word
  function automatic spq_out_t schedule_word(spq_in_t w);
    spq_out_t    r;
    int          q;
    int          lim;
    logic [23:0] desc;
    r = '0;
    if (w.mode == ModeEnq) begin
      q   = w.priority_in % NumQ;
      lim = (int'(limit_q) > Depth) ? Depth : int'(limit_q);
      r.class_out = q[2:0];
      r.size_out  = w.size_in;
      r.flow_out  = w.flow_in;
      if (fill_cnt[q] >= lim) begin
        r.status = StDrop;
      end else begin
        pkt_mem[q][tail_idx[q]] = {w.size_in, w.flow_in};
        tail_idx[q] = (tail_idx[q] + 1) % Depth;
        fill_cnt[q]++;
        r.status = StEnq;
      end
      return r;
    end
    // Pop from the highest-numbered non-empty queue
    r.status = StEmpty;
    for (int k = NumQ - 1; k >= 0; k--) begin
      if (fill_cnt[k] != 0) begin
        desc        = pkt_mem[k][head_idx[k]];
        head_idx[k] = (head_idx[k] + 1) % Depth;
        fill_cnt[k]--;
        r.status    = StDeq;
        r.class_out = k[2:0];
        r.size_out  = desc[23:8];
        r.flow_out  = desc[7:0];
        return r;
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    spq_out_t want;
    if (!rst_ni) begin
      limit_q = LimitReset;
      for (int k = 0; k < NumQ; k++) begin
        head_idx[k] = 0;
        tail_idx[k] = 0;
        fill_cnt[k] = 0;
      end
      due_results.delete();
      results_due_o <= 0;
    end else begin
      // Check the result word against the oldest prediction
      if (result_valid_i) begin
        if (due_results.size() == 0) begin
          flag_mismatch($sformatf("result word %h with no prediction outstanding",
                                  result_i));
        end else begin
          want = due_results.pop_front();
          if (result_i.status !== want.status)
            flag_mismatch($sformatf("status got %0d, expected %0d",
                                    result_i.status, want.status));
          if (result_i.class_out !== want.class_out)
            flag_mismatch($sformatf("class_out got %0d, expected %0d",
                                    result_i.class_out, want.class_out));
          if (result_i.size_out !== want.size_out)
            flag_mismatch($sformatf("size_out got %h, expected %h",
                                    result_i.size_out, want.size_out));
          if (result_i.flow_out !== want.flow_out)
            flag_mismatch($sformatf("flow_out got %h, expected %h",
                                    result_i.flow_out, want.flow_out));
        end
      end
      // Predict the word taken at this edge
      if (start_i && !busy_i) due_results.push_back(schedule_word(item_i));
      // Track limit writes
      if (cfg_valid_i && cfg_ready_i) limit_q = cfg_data_i;
      results_due_o <= due_results.size();
    end
  end

endmodule

// ----- test/tb_strict_priority_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_strict_priority_queue: testbench top for the strict priority queue
// Drives a directed opener (empty pops, class wrap, drops at limits zero and
// one) and then phases of random enqueue/dequeue bursts under several queue
// limits and sender gap rates. The scoreboard runs in spq_checker.
// ----------------------------------------------------------------------------
module tb_strict_priority_queue;
  import spq_pkg::*;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              start     = 1'b0;
  logic              busy;
  spq_in_t           item      = '0;
  logic              result_valid;
  spq_out_t          result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [LimitW-1:0] cfg_data  = '0;
  int                mismatches;
  int                results_due;

  // 4 ns clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  strict_priority_queue dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item),
    .result_valid_o (result_valid),
    .result_o       (result),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_data_i     (cfg_data)
  );

  spq_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .item_i           (item),
    .result_valid_i   (result_valid),
    .result_i         (result),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .mismatch_count_o (mismatches),
    .results_due_o    (results_due)
  );

  // Build an enqueue word
  function automatic spq_in_t pkt_word(logic [7:0] pri, logic [15:0] size,
                                       logic [7:0] flow);
    return '{mode: ModeEnq, priority_in: pri, size_in: size, flow_in: flow};
  endfunction

  // Build a dequeue word; its other fields are don't-care to the block
  function automatic spq_in_t pop_word(logic [7:0] pri, logic [15:0] size,
                                       logic [7:0] flow);
    return '{mode: ModeDeq, priority_in: pri, size_in: size, flow_in: flow};
  endfunction

  // Favor all-zero and all-one values now and then
  function automatic logic [15:0] skewed_value();
    case ($urandom_range(0, 7))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom());
    endcase
  endfunction

  // Random word; focus >= 0 steers enqueues into one class
  function automatic spq_in_t random_word(int enq_pct, int focus);
    spq_in_t w;
    w.mode        = ($urandom_range(0, 99) < enq_pct) ? ModeEnq : ModeDeq;
    w.priority_in = (focus < 0) ? 8'($urandom_range(0, 255))
                                : 8'(focus + NumQueuesDef * $urandom_range(0, 31));
    w.size_in     = skewed_value();
    w.flow_in     = 8'(skewed_value());
    return w;
  endfunction

  // Present a word at the falling edge and hold it until taken
  task automatic send_word(spq_in_t w);
    start <= 1'b1;
    item  <= w;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // Write the queue limit; call only with the block idle
  task automatic write_limit(logic [LimitW-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
  endtask

  // Wait for every predicted word to arrive, then let the pipeline settle
  task automatic wait_drained();
    for (int c = 0; c < 200 && results_due != 0; c++) @(negedge clk_i);
    repeat (3) @(negedge clk_i);
  endtask

  // Random bursts: enqueue-heavy, balanced or dequeue-heavy stretches
  task automatic run_phase(int idle_pct, int count);
    int enq_pct;
    int focus;
    enq_pct = 50;
    focus   = -1;
    for (int n = 0; n < count; n++) begin
      if (n % 32 == 0) begin
        case ($urandom_range(0, 2))
          0:       enq_pct = 85;
          1:       enq_pct = 50;
          default: enq_pct = 15;
        endcase
        focus = ($urandom_range(0, 1) == 0) ? -1 : $urandom_range(0, NumQueuesDef - 1);
      end
      // Hold start low in each cycle at the chosen rate
      while ($urandom_range(0, 99) < idle_pct) begin
        start <= 1'b0;
        @(negedge clk_i);
      end
      send_word(random_word(enq_pct, focus));
    end
    start <= 1'b0;
  endtask

  // Stimulus and verdict
  initial begin
    int limits [6];
    int idles  [6];
    limits = '{31, 1, 16, 0, 5, 16};
    idles  = '{0, 83, 0, 38, 83, 38};

    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset limit: empty pop, class wrap, FIFO order, priority order
    send_word(pop_word(8'hFF, 16'hFFFF, 8'hFF));
    send_word(pkt_word(8'd0, 16'h0000, 8'h00));
    send_word(pkt_word(8'hFF, 16'hFFFF, 8'hFF));
    send_word(pkt_word(8'd8, 16'h1234, 8'h5A));
    send_word(pkt_word(8'd133, 16'h8001, 8'h81));
    repeat (5) send_word(pop_word(8'h00, 16'h0000, 8'h00));
    start <= 1'b0;
    wait_drained();

    // Limit zero: every enqueue drops
    write_limit(5'd0);
    send_word(pkt_word(8'd2, 16'hA5A5, 8'h3C));
    send_word(pkt_word(8'd250, 16'h5A5A, 8'hC3));
    send_word(pop_word(8'h55, 16'hAAAA, 8'h55));
    start <= 1'b0;
    wait_drained();

    // Limit one: second word into a class drops
    write_limit(5'd1);
    send_word(pkt_word(8'd3, 16'h0101, 8'h01));
    send_word(pkt_word(8'd11, 16'h0202, 8'h02));
    send_word(pkt_word(8'd4, 16'h0303, 8'h03));
    repeat (3) send_word(pop_word(8'hAA, 16'h5555, 8'hAA));
    start <= 1'b0;
    wait_drained();

    // Random phases under different limits and gap rates
    for (int p = 0; p < 6; p++) begin
      write_limit(LimitW'(limits[p]));
      run_phase(idles[p], 256);
      wait_drained();
    end

    if (mismatches == 0 && results_due == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #1_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule
